/* hw/rtl/fp8d_pkg.sv */
// Package with the format codes, fixed float32 patterns and decode functions of the FP8 decoder.
`default_nettype none
package fp8d_pkg;

  typedef enum logic [1:0] {
    FMT_E4M3   = 2'd0,
    FMT_E5M2   = 2'd1,
    FMT_E4M3FN = 2'd2,
    FMT_UNKNOWN = 2'd3
  } fmt_t;

  localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;
  localparam logic [30:0] INF_BITS    = 31'h7F80_0000;
  localparam logic [30:0] FN_TOP_BITS = 31'h43E0_0000;

  function automatic logic [31:0] decode_e4m3(input logic [7:0] code, input logic finite);
    logic       s;
    logic [3:0] e;
    logic [2:0] m;
    logic [31:0] r;
    s = code[7];
    e = code[6:3];
    m = code[2:0];
    r = {s, 31'd0};
    if (e == 4'd0) begin
      case (m)
        3'd0:          r = {s, 31'd0};
        3'd1:          r = {s, 8'd118, 23'd0};
        3'd2, 3'd3:    r = {s, 8'd119, m[0], 22'd0};
        default:       r = {s, 8'd120, m[1:0], 21'd0};
      endcase
    end else if (e == 4'hF && !finite) begin
      r = (m == 3'd0) ? {s, INF_BITS} : QNAN_BITS;
    end else if (e == 4'hF && m == 3'h7) begin
      r = {s, FN_TOP_BITS};
    end else begin
      r = {s, 8'(e) + 8'd120, m, 20'd0};
    end
    return r;
  endfunction

  function automatic logic [31:0] decode_e5m2(input logic [7:0] code);
    logic       s;
    logic [4:0] e;
    logic [1:0] m;
    logic [31:0] r;
    s = code[7];
    e = code[6:2];
    m = code[1:0];
    if (e == 5'd0) begin
      case (m)
        2'd0:    r = {s, 31'd0};
        2'd1:    r = {s, 8'd111, 23'd0};
        default: r = {s, 8'd112, m[0], 22'd0};
      endcase
    end else if (e == 5'h1F) begin
      r = (m == 2'd0) ? {s, INF_BITS} : QNAN_BITS;
    end else begin
      r = {s, 8'(e) + 8'd112, m, 21'd0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fp8_to_fp32_decoder.sv */
// Top level of the FP8 to float32 decoder: input register, decode, result register.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_fp8_code[7:0]
//   out     | output    | out_valid/out_stall| out_fp32_bits[31:0]
//   cfg     | input     | cfg_valid/cfg_ready| cfg_format_select[1:0]
//
// One beat is accepted every cycle unless stalled, and its result is registered.
// The two registers advance together unless a held result is stalled.
// Reset clears both valid bits and sets the format to E4M3.
// The configuration port is always ready.
`default_nettype none
module fp8_to_fp32_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_fp8_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_fp32_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_format_select
);

  logic                 hold;
  logic                 v1_r;
  logic [7:0]           code_r;
  logic                 out_valid_r;
  logic [31:0]          out_bits_r;
  logic [31:0]          out_bits_nxt;
  fp8d_pkg::fmt_t       fmt_r;

  assign hold      = out_valid_r && out_stall;
  assign in_stall  = hold;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_fp32_bits = out_bits_r;

  always_comb begin
    unique case (fmt_r)
      fp8d_pkg::FMT_E4M3:   out_bits_nxt = fp8d_pkg::decode_e4m3(code_r, 1'b0);
      fp8d_pkg::FMT_E5M2:   out_bits_nxt = fp8d_pkg::decode_e5m2(code_r);
      fp8d_pkg::FMT_E4M3FN: out_bits_nxt = fp8d_pkg::decode_e4m3(code_r, 1'b1);
      default:              out_bits_nxt = fp8d_pkg::QNAN_BITS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fmt_r       <= fp8d_pkg::FMT_E4M3;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fmt_r <= fp8d_pkg::fmt_t'(cfg_format_select);
      end
      if (!hold) begin
        v1_r        <= in_valid;
        out_valid_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      code_r     <= in_fp8_code;
      out_bits_r <= out_bits_nxt;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted beat not captured");

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !hold) |=> out_valid)
    else $error("captured beat not forwarded");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!v1_r && !hold) |=> !out_valid)
    else $error("result invented");

endmodule
`default_nettype wire

/* tb/sv/fp8_to_fp32_decoder_checker.sv */
// Checker that predicts and compares the decoded float32 results of the FP8 decoder.
`timescale 1ns / 1ps
module fp8_to_fp32_decoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_fp8_code,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_fp32_bits,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_format_select,
  output int          fail_count,
  output int          pending_count
);

  fp8d_pkg::fmt_t cur_fmt;
  logic [31:0]    fp32_queue[$];

  function automatic logic [31:0] fp8_decode(input logic [7:0] code,
                                             input fp8d_pkg::fmt_t fmt);
    int          ew;
    int          mw;
    int          bias;
    int          e;
    int          m;
    int          p;
    int          unb;
    int          frac;
    logic [31:0] sbit;
    logic [7:0]  be;
    if (fmt == fp8d_pkg::FMT_UNKNOWN) return 32'h7FC0_0000;
    ew = (fmt == fp8d_pkg::FMT_E5M2) ? 5 : 4;
    mw = 7 - ew;
    bias = (fmt == fp8d_pkg::FMT_E5M2) ? 15 : 7;
    sbit = {code[7], 31'd0};
    e = (code >> mw) & ((1 << ew) - 1);
    m = code & ((1 << mw) - 1);
    if (e == 0) begin
      if (m == 0) return sbit;
      p = mw - 1;
      while (p > 0 && !m[p]) p--;
      unb = p + 1 - bias - mw;
      frac = (m & ((1 << p) - 1)) << (mw - p);
    end else if (e == (1 << ew) - 1 && fmt != fp8d_pkg::FMT_E4M3FN) begin
      return (m == 0) ? (sbit | 32'h7F80_0000) : 32'h7FC0_0000;
    end else if (e == (1 << ew) - 1 && m == (1 << mw) - 1) begin
      return sbit | 32'h43E0_0000;
    end else begin
      unb = e - bias;
      frac = m;
    end
    be = 8'(unb + 127);
    return sbit | {1'b0, be, 23'd0} | ((32'(frac) << (23 - mw)) & 32'h007F_FFFF);
  endfunction

  assign pending_count = fp32_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_fmt <= fp8d_pkg::FMT_E4M3;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cur_fmt <= fp8d_pkg::fmt_t'(cfg_format_select);
      if (in_valid && !in_stall) fp32_queue.push_back(fp8_decode(in_fp8_code, cur_fmt));
      if (out_valid && !out_stall) begin
        if (fp32_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_fp32_bits);
          fail_count <= fail_count + 1;
        end else if (fp32_queue[0] !== out_fp32_bits) begin
          $display("%0t: fp32_bits mismatch, expected %h, actual %h", $time,
                   fp32_queue[0], out_fp32_bits);
          fail_count <= fail_count + 1;
          void'(fp32_queue.pop_front());
        end else begin
          void'(fp32_queue.pop_front());
        end
      end
    end
  end

endmodule

/* tb/sv/tb_fp8_to_fp32_decoder.sv */
// Testbench top that drives codes and formats into the FP8 decoder and reports the verdict.
`timescale 1ns / 1ps
module tb_fp8_to_fp32_decoder;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_fp8_code;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_fp32_bits;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_format_select;
  int          fail_count;
  int          pending_count;

  fp8_to_fp32_decoder dut (.*);
  fp8_to_fp32_decoder_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("fp8_to_fp32_decoder test failed");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 3) == 0) || ($urandom_range(0, 60) == 0);
      if ($urandom_range(0, 80) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  task automatic send_code(input logic [7:0] code, input bit burst);
    int g;
    g = burst ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_fp8_code <= code;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_format(input fp8d_pkg::fmt_t fmt);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_format_select <= fmt;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] directed[$];
    int         k;
    int         n;
    bit         burst;
    in_valid = 1'b0;
    in_fp8_code = 8'd0;
    cfg_valid = 1'b0;
    cfg_format_select = fp8d_pkg::FMT_E4M3;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed = '{8'h00, 8'h80, 8'h01, 8'h81, 8'h02, 8'h03, 8'h04, 8'h07, 8'h08,
                 8'h38, 8'h78, 8'hF8, 8'h79, 8'h7C, 8'h7F, 8'hFF, 8'h77, 8'h7E,
                 8'hFE, 8'h3C, 8'h55, 8'hAA};
    for (int f = 0; f < 4; f++) begin
      if (f != 0) set_format(fp8d_pkg::fmt_t'(f));
      foreach (directed[i]) send_code(directed[i], 1'b0);
    end
    for (k = 0; k < 7; k++) begin
      set_format(fp8d_pkg::fmt_t'(k == 6 ? 0 : (k == 5 ? 3 : k % 3)));
      burst = 1'b0;
      for (n = 0; n < 250; n++) begin
        if ($urandom_range(0, 9) == 0) burst = ~burst;
        send_code(8'($urandom_range(0, 255)), burst);
      end
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("fp8_to_fp32_decoder test passed");
    end else begin
      $display("fp8_to_fp32_decoder test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fp8d_pkg.sv
hw/rtl/fp8_to_fp32_decoder.sv
tb/sv/fp8_to_fp32_decoder_checker.sv
tb/sv/tb_fp8_to_fp32_decoder.sv
